// ===== sv/afd_pkg.sv =====
`default_nettype none
package afd_pkg;

	localparam int MAX_CODES = 14;
	localparam int CNT_W     = 4;
	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 17;
	localparam int ACC_W     = 33;
	localparam int FRAC_W    = 15;
	localparam int FRAME_W   = 64;
	localparam int CODE_W    = 4;
	localparam int NIB_W     = FRAME_W - 8;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic signed [ACC_W-1:0] ROUND_BIAS = 33'sh4000;

	// register index, taken from paddr above the byte offset
	localparam logic [APB_AW-3:0] REG_STEREO_MODE = 1'd0;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_data;
		logic [CNT_W-1:0]   sample_count;
		logic               restart;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       channel;
		logic                       last;
	} pcm_t;

	typedef struct packed {
		logic en;
		logic first;
	} mac_ctl_t;

	function automatic logic signed [COEF_W-1:0] coef0(input logic [2:0] sel);
		logic signed [COEF_W-1:0] c;
		case (sel)
			3'd0:    c = 17'sd0;
			3'd1:    c = 17'sd30712;
			3'd2:    c = 17'sd28768;
			3'd3:    c = 17'sd29536;
			3'd4:    c = 17'sd32768;
			3'd5:    c = 17'sd20480;
			3'd6:    c = 17'sd18432;
			3'd7:    c = 17'sd20480;
			default: c = 17'sd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [COEF_W-1:0] coef1(input logic [2:0] sel);
		logic signed [COEF_W-1:0] c;
		case (sel)
			3'd0:    c = 17'sd0;
			3'd1:    c = 17'sd0;
			3'd2:    c = 17'sd6144;
			3'd3:    c = -17'sd18432;
			3'd4:    c = -17'sd20480;
			3'd5:    c = -17'sd21504;
			3'd6:    c = 17'sd21504;
			3'd7:    c = 17'sd18432;
			default: c = 17'sd0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== sv/adpcm_frame_decoder.sv =====
// First result of a mono frame: after the frame transaction the decoder passes MUL0, MUL1
//   and FIN, and registers the result in EMIT. One shared multiply-accumulate unit forms both
//   products of each sample. Output backpressure holds EMIT and EMIT_L; a new frame is
//   taken only in IDLE, after the last sample; a frame with zero samples never leaves IDLE.
// Reset: arst_n clears histories, channel phase, left count, stereo_mode and output valid.
`default_nettype none
module adpcm_frame_decoder import afd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              frame_valid,
	output logic                   frame_ready,
	input  wire frame_t            frame,
	output logic                   pcm_valid,
	input  wire logic              pcm_ready,
	output pcm_t                   pcm,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	localparam int SUM_W = 21;
	localparam int PRED_W = ACC_W - FRAC_W;
	localparam logic signed [SUM_W-1:0] SAT_MAX = 21'sd32767;
	localparam logic signed [SUM_W-1:0] SAT_MIN = -21'sd32768;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CODES);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MUL0   = 6'b000010,
		ST_MUL1   = 6'b000100,
		ST_FIN    = 6'b001000,
		ST_EMIT_L = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		KIND_MONO  = 2'd0,
		KIND_LEFT  = 2'd1,
		KIND_RIGHT = 2'd2
	} frame_kind_t;

	state_t      state_q, state_d;
	frame_kind_t kind_q, kind_d;
	logic        ch_q;
	logic [CNT_W-1:0] n_q, pairs_q, idx_q, left_count_q;
	logic [CNT_W-1:0] n_d, lc_eff, pairs_d;
	logic        phase_q, phase_eff, stereo_q;
	logic [NIB_W-1:0] nib_q;
	logic [2:0]  sel_q;
	logic [3:0]  shift_q;
	logic signed [SAMPLE_W-1:0] samp_q, buf_rd_q;
	logic signed [SAMPLE_W-1:0] h1_q [2];
	logic signed [SAMPLE_W-1:0] h2_q [2];
	logic signed [SAMPLE_W-1:0] buf_mem [MAX_CODES];
	logic        pcm_valid_q;
	pcm_t        pcm_q, pcm_d;

	logic        frame_acc, out_free, pcm_load, advance, finish;
	logic        last_idx, pair_last, in_pair, cfg_wr;
	mac_ctl_t    mac_ctl;
	logic signed [COEF_W-1:0] mac_coef;
	logic signed [SAMPLE_W-1:0] mac_hist;
	logic signed [ACC_W-1:0] acc;
	logic signed [PRED_W-1:0] pred;
	logic signed [CODE_W-1:0] code;
	logic signed [SUM_W-1:0] scaled, sum;
	logic signed [SAMPLE_W-1:0] sat;

	assign frame_ready = (state_q == ST_IDLE);
	assign frame_acc   = frame_valid && frame_ready;
	assign out_free    = !pcm_valid_q || pcm_ready;

	// accept-time decode of the frame
	assign n_d       = (frame.sample_count > MAX_CNT) ? MAX_CNT : frame.sample_count;
	assign phase_eff = frame.restart ? 1'b0 : phase_q;
	assign lc_eff    = frame.restart ? '0 : left_count_q;
	assign pairs_d   = (n_d < lc_eff) ? n_d : lc_eff;
	assign kind_d    = !stereo_q ? KIND_MONO : (phase_eff ? KIND_RIGHT : KIND_LEFT);

	assign last_idx  = (idx_q == n_q - 1'b1);
	assign pair_last = (idx_q == pairs_q - 1'b1);
	assign in_pair   = (idx_q < pairs_q);

	// shared multiply-accumulate: c0*h1 then c1*h2
	assign mac_ctl.en    = (state_q == ST_MUL0) || (state_q == ST_MUL1);
	assign mac_ctl.first = (state_q == ST_MUL0);
	assign mac_coef = (state_q == ST_MUL0) ? coef0(sel_q) : coef1(sel_q);
	assign mac_hist = (state_q == ST_MUL0) ? h1_q[ch_q] : h2_q[ch_q];

	afd_mac u_mac (
		.clk  (clk),
		.ctl  (mac_ctl),
		.coef (mac_coef),
		.hist (mac_hist),
		.acc  (acc)
	);

	assign pred   = acc[ACC_W-1:FRAC_W];
	assign code   = nib_q[NIB_W-1 -: CODE_W];
	assign scaled = SUM_W'(code) <<< shift_q;
	assign sum    = SUM_W'(pred) + scaled;

	always_comb begin
		if (sum > SAT_MAX) begin
			sat = SAT_MAX[SAMPLE_W-1:0];
		end else if (sum < SAT_MIN) begin
			sat = SAT_MIN[SAMPLE_W-1:0];
		end else begin
			sat = sum[SAMPLE_W-1:0];
		end
	end

	always_comb begin
		state_d  = state_q;
		advance  = 1'b0;
		finish   = 1'b0;
		pcm_load = 1'b0;
		pcm_d    = pcm_q;
		case (state_q)
			ST_IDLE: begin
				if (frame_acc && (n_d != '0)) begin
					state_d = ST_MUL0;
				end
			end
			ST_MUL0: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_FIN;
			ST_FIN: begin
				case (kind_q)
					KIND_MONO: state_d = ST_EMIT;
					KIND_RIGHT: begin
						if (in_pair) begin
							state_d = ST_EMIT_L;
						end else if (last_idx) begin
							state_d = ST_IDLE;
							finish  = 1'b1;
						end else begin
							state_d = ST_MUL0;
							advance = 1'b1;
						end
					end
					default: begin
						if (last_idx) begin
							state_d = ST_IDLE;
							finish  = 1'b1;
						end else begin
							state_d = ST_MUL0;
							advance = 1'b1;
						end
					end
				endcase
			end
			ST_EMIT_L: begin
				if (out_free) begin
					pcm_load      = 1'b1;
					pcm_d.sample  = buf_rd_q;
					pcm_d.channel = 1'b0;
					pcm_d.last    = 1'b0;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					pcm_load      = 1'b1;
					pcm_d.sample  = samp_q;
					pcm_d.channel = ch_q;
					pcm_d.last    = (kind_q == KIND_RIGHT) ? pair_last : last_idx;
					if (last_idx) begin
						state_d = ST_IDLE;
						finish  = 1'b1;
					end else begin
						state_d = ST_MUL0;
						advance = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kind_q       <= KIND_MONO;
			ch_q         <= 1'b0;
			n_q          <= '0;
			pairs_q      <= '0;
			idx_q        <= '0;
			left_count_q <= '0;
			phase_q      <= 1'b0;
			h1_q[0]      <= '0;
			h1_q[1]      <= '0;
			h2_q[0]      <= '0;
			h2_q[1]      <= '0;
			pcm_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (frame_acc) begin
				kind_q  <= kind_d;
				ch_q    <= (kind_d == KIND_RIGHT);
				n_q     <= n_d;
				pairs_q <= pairs_d;
				idx_q   <= '0;
				if (frame.restart) begin
					h1_q[0] <= '0;
					h1_q[1] <= '0;
					h2_q[0] <= '0;
					h2_q[1] <= '0;
				end
				// an empty left or right frame still moves the stereo phase
				if (n_d == '0) begin
					case (kind_d)
						KIND_LEFT: begin
							left_count_q <= '0;
							phase_q      <= 1'b1;
						end
						KIND_RIGHT: begin
							left_count_q <= '0;
							phase_q      <= 1'b0;
						end
						default: begin
							left_count_q <= lc_eff;
							phase_q      <= phase_eff;
						end
					endcase
				end else begin
					left_count_q <= lc_eff;
					phase_q      <= phase_eff;
				end
			end
			if (state_q == ST_FIN) begin
				h2_q[ch_q] <= h1_q[ch_q];
				h1_q[ch_q] <= sat;
			end
			if (advance) begin
				idx_q <= idx_q + 1'b1;
			end
			if (finish) begin
				case (kind_q)
					KIND_LEFT: begin
						left_count_q <= n_q;
						phase_q      <= 1'b1;
					end
					KIND_RIGHT: begin
						left_count_q <= '0;
						phase_q      <= 1'b0;
					end
					default: ;
				endcase
			end
			if (pcm_load) begin
				pcm_valid_q <= 1'b1;
			end else if (pcm_ready) begin
				pcm_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_acc) begin
			nib_q   <= frame.frame_data[NIB_W-1:0];
			sel_q   <= frame.frame_data[FRAME_W-6 -: 3];
			shift_q <= frame.frame_data[FRAME_W-1 -: 4];
		end else if (advance) begin
			nib_q <= {nib_q[NIB_W-CODE_W-1:0], {CODE_W{1'b0}}};
		end
		if (state_q == ST_FIN) begin
			samp_q <= sat;
		end
		if (pcm_load) begin
			pcm_q <= pcm_d;
		end
	end

	// left frame buffer, registered read at the current sample index
	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && (kind_q == KIND_LEFT)) begin
			buf_mem[idx_q] <= sat;
		end
		buf_rd_q <= buf_mem[idx_q];
	end

	assign pcm_valid = pcm_valid_q;
	assign pcm       = pcm_q;

	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q <= 1'b0;
		end else if (cfg_wr && (paddr[APB_AW-1:2] == REG_STEREO_MODE)) begin
			stereo_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1:2] == REG_STEREO_MODE) ?
		{{(APB_DW-1){1'b0}}, stereo_q} : '0;

	a_left_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == KIND_LEFT && state_q != ST_IDLE) |-> !pcm_load)
		else $error("result emitted during a left frame");

	a_left_count: assert property (@(posedge clk) disable iff (!arst_n)
		left_count_q <= MAX_CNT)
		else $error("left count beyond buffer depth");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_L && out_free) |=> (state_q == ST_EMIT))
		else $error("left sample not followed by right sample");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (idx_q < n_q))
		else $error("sample index past frame count");

endmodule
`default_nettype wire

// ===== sv/afd_mac.sv =====
`default_nettype none
module afd_mac import afd_pkg::*; (
	input  wire logic                     clk,
	input  wire mac_ctl_t                 ctl,
	input  wire logic signed [COEF_W-1:0] coef,
	input  wire logic signed [SAMPLE_W-1:0] hist,
	output logic signed [ACC_W-1:0]       acc
);

	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] acc_q;

	assign prod = ACC_W'(coef) * ACC_W'(hist);

	// first product starts from the rounding bias, second one accumulates
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.first) begin
				acc_q <= prod + ROUND_BIAS;
			end else begin
				acc_q <= acc_q + prod;
			end
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

// ===== dv/adpcm_frame_checker.sv =====
module adpcm_frame_checker import afd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              frame_valid,
	input  wire logic              frame_ready,
	input  wire frame_t            frame,
	input  wire logic              pcm_valid,
	input  wire logic              pcm_ready,
	input  wire pcm_t              pcm,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	input  wire logic [APB_DW-1:0] prdata,
	input  wire logic              pready,
	output int                     fail_count,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAIR_C0 [8] = '{0, 30712, 28768, 29536, 32768, 20480, 18432, 20480};
	localparam int PAIR_C1 [8] = '{0, 0, 6144, -18432, -20480, -21504, 21504, 18432};
	localparam longint SAT_HI = 2 ** (SAMPLE_W - 1) - 1;
	localparam longint SAT_LO = -(2 ** (SAMPLE_W - 1));

	logic                       stereo;
	logic signed [SAMPLE_W-1:0] hist1 [2];
	logic signed [SAMPLE_W-1:0] hist2 [2];
	logic signed [SAMPLE_W-1:0] left_buf [MAX_CODES];
	int                         left_len;
	bit                         expect_right;
	pcm_t                       pcm_due [$];

	task automatic decode_channel(input logic [FRAME_W-1:0] data, input int n, input int ch,
		output logic signed [SAMPLE_W-1:0] dst [MAX_CODES]);
		logic [2:0]               sel;
		logic [3:0]               shift;
		logic signed [CODE_W-1:0] nib;
		longint                   acc;
		sel = data[58:56];
		shift = data[63:60];
		for (int i = 0; i < n; i++) begin
			nib = data[NIB_W-1-CODE_W*i -: CODE_W];
			// arithmetic shift floors the rounded prediction
			acc = (longint'(PAIR_C0[sel]) * hist1[ch] + longint'(PAIR_C1[sel]) * hist2[ch]
				+ 64'sh4000) >>> FRAC_W;
			acc += longint'(nib) <<< shift;
			if (acc > SAT_HI)
				acc = SAT_HI;
			else if (acc < SAT_LO)
				acc = SAT_LO;
			hist2[ch] = hist1[ch];
			hist1[ch] = acc[SAMPLE_W-1:0];
			dst[i] = acc[SAMPLE_W-1:0];
		end
	endtask

	task automatic decode_frame(input frame_t f);
		logic signed [SAMPLE_W-1:0] smp [MAX_CODES];
		int                         n;
		int                         pairs;
		n = (f.sample_count > MAX_CODES) ? MAX_CODES : int'(f.sample_count);
		if (f.restart) begin
			foreach (hist1[c]) begin
				hist1[c] = '0;
				hist2[c] = '0;
			end
			left_len = 0;
			expect_right = 1'b0;
		end
		if (!stereo) begin
			decode_channel(f.frame_data, n, 0, smp);
			for (int i = 0; i < n; i++)
				pcm_due.push_back(pcm_t'{sample: smp[i], channel: 1'b0, last: i == n - 1});
		end else if (!expect_right) begin
			// hold the left frame until its right partner arrives
			decode_channel(f.frame_data, n, 0, left_buf);
			left_len = n;
			expect_right = 1'b1;
		end else begin
			decode_channel(f.frame_data, n, 1, smp);
			pairs = (n < left_len) ? n : left_len;
			for (int i = 0; i < pairs; i++) begin
				pcm_due.push_back(pcm_t'{sample: left_buf[i], channel: 1'b0, last: 1'b0});
				pcm_due.push_back(pcm_t'{sample: smp[i], channel: 1'b1, last: i == pairs - 1});
			end
			left_len = 0;
			expect_right = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		pcm_t want;
		if (!arst_n) begin
			stereo = 1'b0;
			foreach (hist1[c]) begin
				hist1[c] = '0;
				hist2[c] = '0;
			end
			left_len = 0;
			expect_right = 1'b0;
			pcm_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pready && paddr[APB_AW-1:2] == REG_STEREO_MODE) begin
				if (pwrite) begin
					stereo = pwdata[0];
				end else if (prdata !== APB_DW'(stereo)) begin
					$display("%0t stereo_mode read: expected %0h, got %0h", $time,
						APB_DW'(stereo), prdata);
					fail_count++;
				end
			end
			if (pcm_valid && pcm_ready) begin
				if (pcm_due.size() == 0) begin
					$display("%0t pcm transaction with nothing expected: sample %0d channel %0b last %0b",
						$time, $signed(pcm.sample), pcm.channel, pcm.last);
					fail_count++;
				end else begin
					want = pcm_due.pop_front();
					if (pcm.sample !== want.sample || pcm.channel !== want.channel
						|| pcm.last !== want.last) begin
						$display("%0t pcm mismatch: expected sample %0d channel %0b last %0b, got sample %0d channel %0b last %0b",
							$time, $signed(want.sample), want.channel, want.last,
							$signed(pcm.sample), pcm.channel, pcm.last);
						fail_count++;
					end
				end
			end
			if (frame_valid && frame_ready)
				decode_frame(frame);
			pending = pcm_due.size();
		end
	end

endmodule

// ===== dv/tb_adpcm_frame_decoder.sv =====
module tb_adpcm_frame_decoder;
	timeunit 1ns;
	timeprecision 1ps;
	import afd_pkg::*;

	localparam int DRAIN_CYCLES = 80;
	localparam int PHASE_FRAMES = 15;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              frame_valid = 1'b0;
	logic              frame_ready;
	frame_t            frame = '0;
	logic              pcm_valid;
	logic              pcm_ready = 1'b0;
	pcm_t              pcm;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	int                fail_count;
	int                pending;
	bit                idle_on = 1'b1;

	adpcm_frame_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame),
		.pcm_valid   (pcm_valid),
		.pcm_ready   (pcm_ready),
		.pcm         (pcm),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	adpcm_frame_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame),
		.pcm_valid   (pcm_valid),
		.pcm_ready   (pcm_ready),
		.pcm         (pcm),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	// stall the pcm side in short bursts
	initial begin : pcm_sink
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				pcm_ready <= 1'b0;
				hold--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				pcm_ready <= 1'b0;
				hold = $urandom_range(0, 3);
			end else begin
				pcm_ready <= 1'b1;
			end
		end
	end

	function automatic logic [NIB_W-1:0] rand_codes();
		return NIB_W'({$urandom, $urandom});
	endfunction

	function automatic frame_t mk_frame(input logic [7:0] hdr, input logic [NIB_W-1:0] codes,
		input logic [CNT_W-1:0] cnt, input logic rst);
		frame_t f;
		f.frame_data = {hdr, codes};
		f.sample_count = cnt;
		f.restart = rst;
		return f;
	endfunction

	function automatic frame_t random_frame();
		logic [7:0] hdr;
		hdr = 8'($urandom);
		// keep the shift small half the time so the predictor dominates
		if ($urandom_range(0, 1))
			hdr[7:4] = 4'($urandom_range(0, 3));
		return mk_frame(hdr, rand_codes(), CNT_W'($urandom_range(0, 15)),
			$urandom_range(0, 11) == 0);
	endfunction

	// call at a falling edge; leaves valid high for the next frame or a caller to drop
	task automatic send_frame(input frame_t f);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			frame_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		frame <= f;
		frame_valid <= 1'b1;
		do @(posedge clk); while (!frame_ready);
		@(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {REG_STEREO_MODE, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// drain the decoder, then write and read back the mode
	task automatic set_stereo(input logic mode);
		frame_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		apb_access(1'b1, APB_DW'(mode));
		apb_access(1'b0, '0);
	endtask

	initial begin : stimulus
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_stereo(1'b0);
		send_frame(mk_frame(8'h00, '0, 4'd14, 1'b1));
		send_frame(mk_frame(8'hF1, {14{4'h7}}, 4'd14, 1'b0));
		send_frame(mk_frame(8'hF4, {14{4'h8}}, 4'd14, 1'b0));
		send_frame(mk_frame(8'h0F, rand_codes(), 4'd15, 1'b0));
		send_frame(mk_frame(8'hFF, '1, 4'd0, 1'b0));
		for (int s = 0; s < 8; s++)
			send_frame(mk_frame({4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 3'(s)},
				rand_codes(), 4'd14, 1'b0));

		set_stereo(1'b1);
		send_frame(mk_frame(8'h12, rand_codes(), 4'd14, 1'b1));
		send_frame(mk_frame(8'h23, rand_codes(), 4'd14, 1'b0));
		// right frame longer than its left
		send_frame(mk_frame(8'h31, rand_codes(), 4'd5, 1'b0));
		send_frame(mk_frame(8'h26, rand_codes(), 4'd14, 1'b0));
		// right frame shorter than its left
		send_frame(mk_frame(8'h47, rand_codes(), 4'd14, 1'b0));
		send_frame(mk_frame(8'h15, rand_codes(), 4'd3, 1'b0));
		// empty left frame still flips the channel
		send_frame(mk_frame(8'h02, rand_codes(), 4'd0, 1'b0));
		send_frame(mk_frame(8'h13, rand_codes(), 4'd6, 1'b0));
		// restart in the middle of a pair starts a new left frame
		send_frame(mk_frame(8'h21, rand_codes(), 4'd7, 1'b0));
		send_frame(mk_frame(8'h34, rand_codes(), 4'd4, 1'b1));
		send_frame(mk_frame(8'h16, rand_codes(), 4'd9, 1'b0));
		// empty right frame
		send_frame(mk_frame(8'h22, rand_codes(), 4'd8, 1'b0));
		send_frame(mk_frame(8'h25, rand_codes(), 4'd0, 1'b0));

		for (int p = 0; p < 5; p++) begin
			set_stereo(1'(p % 2));
			idle_on = (p < 4);
			repeat (PHASE_FRAMES) send_frame(random_frame());
		end

		frame_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
